[rtl/dmsr_pkg.sv]
// Shared types, widths and codes for the dual motor speed ramp unit.
`default_nettype none

package dmsr_pkg;

    localparam int SPEED_W    = 9;
    localparam int DUTY_W     = 8;
    localparam int STEP_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int DUTY_MAX_DEF = 255;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [DUTY_W-1:0] duty_t;

    typedef enum logic
    {
        REG_SLEW_STEP     = 1'b0,
        REG_STEP_INTERVAL = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        FUNC_SET_GOALS = 1'b0,
        FUNC_TICK      = 1'b1
    } func_t;

    typedef struct packed
    {
        logic  reverse;
        duty_t duty;
        logic  at_goal;
    } wheel_status_t;

    localparam logic [STEP_W-1:0]     SLEW_STEP_RST     = 8'd10;
    localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST = 16'd5;

endpackage

`default_nettype wire

[rtl/dmsr_slew.sv]
// One wheel channel: moves a speed toward its goal by one step and derives sign and duty.
`default_nettype none

module dmsr_slew
#(
    parameter int DUTY_MAX = dmsr_pkg::DUTY_MAX_DEF
)
(
    input  wire dmsr_pkg::speed_t          cur,
    input  wire dmsr_pkg::speed_t          goal,
    input  wire [dmsr_pkg::STEP_W-1:0]     step,
    output dmsr_pkg::speed_t               speed_next,
    output dmsr_pkg::wheel_status_t        status
);
    import dmsr_pkg::*;

    localparam int LIM_INT = (DUTY_MAX > 255) ? 255 : DUTY_MAX;
    localparam logic [SPEED_W:0] LIM = (SPEED_W + 1)'(LIM_INT);

    logic signed [SPEED_W+1:0] cur_x;
    logic signed [SPEED_W+1:0] goal_x;
    logic signed [SPEED_W+1:0] step_x;
    logic signed [SPEED_W+1:0] up;
    logic signed [SPEED_W+1:0] down;
    logic signed [SPEED_W:0]   nxt_x;
    logic [SPEED_W:0]          mag;

    always_comb
    begin
        cur_x  = (SPEED_W + 2)'(cur);
        goal_x = (SPEED_W + 2)'(goal);
        step_x = $signed({{(SPEED_W + 2 - STEP_W){1'b0}}, step});
        up     = cur_x + step_x;
        down   = cur_x - step_x;
        if (cur < goal)
        begin
            speed_next = (up > goal_x) ? goal : up[SPEED_W-1:0];
        end
        else if (cur > goal)
        begin
            speed_next = (down < goal_x) ? goal : down[SPEED_W-1:0];
        end
        else
        begin
            speed_next = cur;
        end
        nxt_x = (SPEED_W + 1)'(speed_next);
        mag   = nxt_x[SPEED_W] ? (SPEED_W + 1)'(-nxt_x) : nxt_x;
        status.reverse = speed_next[SPEED_W-1];
        status.duty    = (mag > LIM) ? DUTY_W'(LIM) : DUTY_W'(mag);
        status.at_goal = (speed_next == goal);
    end

endmodule

`default_nettype wire

[rtl/dual_motor_speed_ramp_unit.sv]
// Top level of the dual motor speed ramp unit: stream ports, state and result register.
`default_nettype none

// Two-channel speed ramp for a differential drive. A transfer with tuser 0 loads
// new signed goals for both wheels; a transfer with tuser 1 is one time tick. On
// every step_interval-th tick each wheel speed moves toward its goal by the slew
// step, stopping exactly at the goal, and one result transfer carries direction,
// duty and a settled flag. The state update and the result are formed in a single
// pass into the output register, and a new transfer is accepted in every cycle
// while the output register is free or being emptied in the same cycle.
module dual_motor_speed_ramp_unit
#(
    parameter int DUTY_MAX = dmsr_pkg::DUTY_MAX_DEF
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // left_goal_in [8:0], right_goal_in [17:9], zeros above
    input  wire [dmsr_pkg::S_TDATA_W-1:0]       s_tdata,
    // func
    input  wire                                 s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // left_reverse [0], left_duty [8:1], right_reverse [9], right_duty [17:10],
    // settled [18], zeros above
    output logic [dmsr_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire                                 cfg_index,
    input  wire [dmsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dmsr_pkg::*;

    logic [STEP_W-1:0]     slew_step_reg;
    logic [INTERVAL_W-1:0] step_interval_reg;
    logic [INTERVAL_W-1:0] tick_count_reg;
    speed_t                left_speed_reg;
    speed_t                right_speed_reg;
    speed_t                left_goal_reg;
    speed_t                right_goal_reg;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    speed_t        left_speed_next;
    speed_t        right_speed_next;
    wheel_status_t left_status;
    wheel_status_t right_status;
    logic          in_xfer;
    logic          is_tick;
    logic          do_step;
    logic [INTERVAL_W:0] count_inc;

    dmsr_slew #(.DUTY_MAX(DUTY_MAX)) u_left
    (
        .cur        (left_speed_reg),
        .goal       (left_goal_reg),
        .step       (slew_step_reg),
        .speed_next (left_speed_next),
        .status     (left_status)
    );

    dmsr_slew #(.DUTY_MAX(DUTY_MAX)) u_right
    (
        .cur        (right_speed_reg),
        .goal       (right_goal_reg),
        .step       (slew_step_reg),
        .speed_next (right_speed_next),
        .status     (right_status)
    );

    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        in_xfer   = s_tvalid && s_tready;
        is_tick   = (func_t'(s_tuser) == FUNC_TICK);
        count_inc = {1'b0, tick_count_reg} + (INTERVAL_W + 1)'(1);
        do_step   = in_xfer && is_tick && !(count_inc < {1'b0, step_interval_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_step_reg     <= SLEW_STEP_RST;
            step_interval_reg <= STEP_INTERVAL_RST;
            tick_count_reg    <= '0;
            left_speed_reg    <= '0;
            right_speed_reg   <= '0;
            left_goal_reg     <= '0;
            right_goal_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SLEW_STEP:     slew_step_reg     <= cfg_data[STEP_W-1:0];
                    REG_STEP_INTERVAL: step_interval_reg <= cfg_data[INTERVAL_W-1:0];
                    default:           ;
                endcase
            end
            if (in_xfer && !is_tick)
            begin
                left_goal_reg  <= s_tdata[SPEED_W-1:0];
                right_goal_reg <= s_tdata[2*SPEED_W-1:SPEED_W];
            end
            if (in_xfer && is_tick)
            begin
                tick_count_reg <= do_step ? '0 : count_inc[INTERVAL_W-1:0];
            end
            if (do_step)
            begin
                left_speed_reg  <= left_speed_next;
                right_speed_reg <= right_speed_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_data_reg <= {
                (M_TDATA_W - 2*DUTY_W - 3)'(0),
                left_status.at_goal && right_status.at_goal,
                right_status.duty,
                right_status.reverse,
                left_status.duty,
                left_status.reverse
            };
        end
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the dual motor speed ramp unit.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dmsr_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WHEEL_DUTY_CAP = (DUTY_MAX_DEF > 255) ? 255 : DUTY_MAX_DEF;

    typedef struct {
        func_t  func;
        speed_t left;
        speed_t right;
    } motion_cmd_t;

    typedef struct {
        logic  left_rev;
        duty_t left_duty;
        logic  right_rev;
        duty_t right_duty;
        logic  settled;
    } wheel_report_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    motion_cmd_t   pending_cmds[$];
    wheel_report_t expected_reports[$];
    motion_cmd_t   held_cmd;

    speed_t            speed_l, speed_r, goal_l, goal_r;
    int                tick_cnt;
    logic [STEP_W-1:0] step_size;
    logic [INTERVAL_W-1:0] step_period;

    bit no_stall = 1'b0;
    int mismatches = 0;
    int cycles = 0;

    dual_motor_speed_ramp_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    function automatic speed_t slew_toward(speed_t cur, speed_t goal, int step);
        int c;
        int g;
        c = cur;
        g = goal;
        if (c < g)
        begin
            c = c + step;
            if (c > g)
                c = g;
        end
        else if (c > g)
        begin
            c = c - step;
            if (c < g)
                c = g;
        end
        return speed_t'(c);
    endfunction

    function automatic duty_t duty_of_speed(speed_t s);
        int v;
        v = s;
        if (v < 0)
            v = -v;
        if (v > WHEEL_DUTY_CAP)
            v = WHEEL_DUTY_CAP;
        return duty_t'(v);
    endfunction

    function automatic void advance_ramp(motion_cmd_t c);
        wheel_report_t r;
        if (c.func == FUNC_SET_GOALS)
        begin
            goal_l = c.left;
            goal_r = c.right;
            return;
        end
        if (tick_cnt + 1 < int'(step_period))
        begin
            tick_cnt = tick_cnt + 1;
            return;
        end
        tick_cnt = 0;
        speed_l = slew_toward(speed_l, goal_l, int'(step_size));
        speed_r = slew_toward(speed_r, goal_r, int'(step_size));
        r.left_rev   = speed_l < 0;
        r.left_duty  = duty_of_speed(speed_l);
        r.right_rev  = speed_r < 0;
        r.right_duty = duty_of_speed(speed_r);
        r.settled    = (speed_l == goal_l) && (speed_r == goal_r);
        expected_reports.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                advance_ramp(held_cmd);
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() > 0 && (no_stall || $urandom_range(0, 99) >= 32))
                begin
                    held_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= held_cmd.func;
                    s_tdata  <= {6'b0, held_cmd.right, held_cmd.left};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        wheel_report_t w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result transfer %h", m_tdata));
                end
                else
                begin
                    w = expected_reports.pop_front();
                    if (m_tdata[0] !== w.left_rev)
                        report_mismatch($sformatf("left_reverse %b, want %b",
                                                  m_tdata[0], w.left_rev));
                    if (m_tdata[8:1] !== w.left_duty)
                        report_mismatch($sformatf("left_duty %0d, want %0d",
                                                  m_tdata[8:1], w.left_duty));
                    if (m_tdata[9] !== w.right_rev)
                        report_mismatch($sformatf("right_reverse %b, want %b",
                                                  m_tdata[9], w.right_rev));
                    if (m_tdata[17:10] !== w.right_duty)
                        report_mismatch($sformatf("right_duty %0d, want %0d",
                                                  m_tdata[17:10], w.right_duty));
                    if (m_tdata[18] !== w.settled)
                        report_mismatch($sformatf("settled %b, want %b",
                                                  m_tdata[18], w.settled));
                    if (m_tdata[M_TDATA_W-1:19] !== '0)
                        report_mismatch($sformatf("padding bits %h not zero",
                                                  m_tdata[M_TDATA_W-1:19]));
                end
            end
            m_tready <= no_stall || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic queue_goals(input speed_t l, input speed_t r);
        motion_cmd_t c;
        c.func  = FUNC_SET_GOALS;
        c.left  = l;
        c.right = r;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_ticks(input int n);
        motion_cmd_t c;
        c.func  = FUNC_TICK;
        c.left  = speed_t'($urandom_range(0, 511));
        c.right = speed_t'($urandom_range(0, 511));
        repeat (n)
            pending_cmds.push_back(c);
    endtask

    task automatic wait_for_idle();
        while (pending_cmds.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SLEW_STEP)
            step_size = val[STEP_W-1:0];
        else
            step_period = val[INTERVAL_W-1:0];
    endtask

    function automatic speed_t pick_goal();
        case ($urandom_range(0, 9))
            0: return speed_t'(255);
            1: return speed_t'(-255);
            2: return speed_t'(-256);
            3: return speed_t'(0);
            default: return speed_t'($urandom_range(0, 511));
        endcase
    endfunction

    initial
    begin
        int n_items;
        speed_l     = '0;
        speed_r     = '0;
        goal_l      = '0;
        goal_r      = '0;
        tick_cnt    = 0;
        step_size   = SLEW_STEP_RST;
        step_period = STEP_INTERVAL_RST;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: extreme goals, then reversed goals that ramp both speeds back to zero.
        queue_goals(speed_t'(255), speed_t'(-256));
        queue_ticks(5);
        queue_goals(speed_t'(-255), speed_t'(255));
        queue_ticks(5);
        wait_for_idle();

        // Full step every tick; the goal of -256 saturates the duty.
        write_reg(REG_SLEW_STEP, 16'd255);
        write_reg(REG_STEP_INTERVAL, 16'd1);
        queue_goals(speed_t'(255), speed_t'(-256));
        queue_ticks(2);
        queue_goals(speed_t'(7), speed_t'(-7));
        queue_ticks(2);
        wait_for_idle();

        // A zero step freezes the speeds; a zero interval steps on every tick.
        write_reg(REG_SLEW_STEP, 16'd0);
        write_reg(REG_STEP_INTERVAL, 16'd0);
        queue_goals(speed_t'(100), speed_t'(-100));
        queue_ticks(2);
        wait_for_idle();

        // Longest interval, then lowered below the running tick count.
        write_reg(REG_SLEW_STEP, 16'd3);
        write_reg(REG_STEP_INTERVAL, 16'd65535);
        queue_ticks(3);
        wait_for_idle();
        write_reg(REG_STEP_INTERVAL, 16'd1);
        queue_ticks(2);
        wait_for_idle();

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_SLEW_STEP, 16'd255);
                    write_reg(REG_STEP_INTERVAL, 16'd1);
                end
                1:
                begin
                    write_reg(REG_SLEW_STEP, 16'd1);
                    write_reg(REG_STEP_INTERVAL, 16'd2);
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        write_reg(REG_SLEW_STEP, 16'($urandom_range(0, 255)));
                    else
                        write_reg(REG_SLEW_STEP, 16'($urandom_range(1, 40)));
                    write_reg(REG_STEP_INTERVAL, 16'($urandom_range(0, 6)));
                end
            endcase
            no_stall = (p == 5);
            n_items = 0;
            while (n_items < 60)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    queue_goals(pick_goal(), pick_goal());
                    n_items++;
                end
                else
                begin
                    queue_ticks(1);
                    n_items++;
                end
                if (p == 3 && n_items == 30)
                    wait_for_idle();
            end
            wait_for_idle();
        end
        no_stall = 1'b0;

        wait_for_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[sim.f]
rtl/dmsr_pkg.sv
rtl/dmsr_slew.sv
rtl/dual_motor_speed_ramp_unit.sv
dv/tb_top.sv
